FILE: hdl/rrs_pkg.sv
// Shared types, widths and register codes for the raster run segmenter.
package rrs_pkg;

   localparam int DEF_MAX_WIDTH   = 64;
   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_QUEUE_DEPTH = 4;

   localparam int PIX_W       = 2;
   localparam int START_W     = 6;
   localparam int END_W       = 7;
   localparam int ROW_OUT_W   = 6;
   localparam int DEPTH_W     = 10;
   localparam int ROW_WIDTH_W = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [ROW_WIDTH_W-1:0] RST_ROW_WIDTH  = 7'd50;
   localparam logic [DEPTH_W-1:0]     RST_DEPTH_ONE   = 10'd60;
   localparam logic [DEPTH_W-1:0]     RST_DEPTH_TWO   = 10'd30;
   localparam logic [DEPTH_W-1:0]     RST_DEPTH_THREE = 10'd0;

   localparam logic [PIX_W-1:0] LEVEL_NONE  = 2'd0;
   localparam logic [PIX_W-1:0] LEVEL_ONE   = 2'd1;
   localparam logic [PIX_W-1:0] LEVEL_TWO   = 2'd2;
   localparam logic [PIX_W-1:0] LEVEL_THREE = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_WIDTH   = 2'd0,
      CSR_DEPTH_ONE   = 2'd1,
      CSR_DEPTH_TWO   = 2'd2,
      CSR_DEPTH_THREE = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] one;
      logic [DEPTH_W-1:0] two;
      logic [DEPTH_W-1:0] three;
   } depth_cfg_type;

   // Everything one pixel closes: an optional run ended by a level change
   // and an optional run ended by the row boundary.
   typedef struct packed {
      logic                 has_a;
      logic [START_W-1:0]   a_start;
      logic [END_W-1:0]     a_end;
      logic [PIX_W-1:0]     a_level;
      logic                 has_b;
      logic [START_W-1:0]   b_start;
      logic [END_W-1:0]     b_end;
      logic [PIX_W-1:0]     b_level;
      logic [ROW_OUT_W-1:0] row;
   } seg_pair_type;

   typedef struct packed {
      logic [START_W-1:0]   start;
      logic [END_W-1:0]     end_col;
      logic [ROW_OUT_W-1:0] row;
      logic [PIX_W-1:0]     level;
      logic                 last;
   } seg_out_type;

endpackage

FILE: hdl/rrs_req_if.sv
// Pixel request channel.
interface rrs_req_if;
   import rrs_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_level;

   modport source (output valid, output pixel_level, input ready);
   modport sink   (input valid, input pixel_level, output ready);
endinterface

FILE: hdl/rrs_rsp_if.sv
// Segment response channel.
interface rrs_rsp_if;
   import rrs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [START_W-1:0]   seg_start;
   logic [END_W-1:0]     seg_end;
   logic [ROW_OUT_W-1:0] seg_row;
   logic [PIX_W-1:0]     seg_level;
   logic [DEPTH_W-1:0]   seg_depth;
   logic                 last_of_item;

   modport source (output valid, output seg_start, output seg_end, output seg_row,
                   output seg_level, output seg_depth, output last_of_item,
                   input ready);
   modport sink   (input valid, input seg_start, input seg_end, input seg_row,
                   input seg_level, input seg_depth, input last_of_item,
                   output ready);
endinterface

FILE: hdl/rrs_front.sv
// Front end: tracks column, row and open run, classifies each pixel.
module rrs_front #(
   parameter int MAX_WIDTH = rrs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_ROWS  = rrs_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   rrs_req_if.sink                          req_ch,
   input  logic [rrs_pkg::ROW_WIDTH_W-1:0]  row_width,
   input  logic                             queue_full,
   output logic                             push,
   output rrs_pkg::seg_pair_type            push_data
);
   import rrs_pkg::*;

   localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SPAN_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W   = (SPAN_W > ROW_WIDTH_W) ? SPAN_W : ROW_WIDTH_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             run_open_ff, run_open_in;
   logic [PIX_W-1:0] run_level_ff, run_level_in;
   logic [COL_W-1:0] run_start_ff, run_start_in;

   logic [CMP_W-1:0] width_raw;
   logic [CMP_W-1:0] width_eff;
   logic [CMP_W-1:0] col_next;
   logic             row_end;
   logic             accept;
   logic             close_a;
   logic             still_open;
   logic             new_open;
   logic             open_mid;
   logic             close_b;
   logic [PIX_W-1:0] level;

   assign level        = req_ch.pixel_level;
   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;

   // Effective width: zero acts as one, anything past the maximum is clamped.
   assign width_raw = CMP_W'(row_width);
   always_comb begin
      if (width_raw == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
   end

   assign col_next = CMP_W'(col_ff) + CMP_W'(1);
   assign row_end  = (col_next >= width_eff);

   assign close_a    = run_open_ff && (level != run_level_ff);
   assign still_open = run_open_ff && !close_a;
   assign new_open   = !still_open && (level != LEVEL_NONE);
   assign open_mid   = still_open || new_open;
   assign close_b    = row_end && open_mid;

   always_comb begin
      run_level_in = new_open ? level : run_level_ff;
      run_start_in = new_open ? col_ff : run_start_ff;
      run_open_in  = open_mid && !row_end;
      if (row_end) begin
         col_in = '0;
         row_in = (row_ff == ROW_W'(MAX_ROWS - 1)) ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = COL_W'(col_next);
         row_in = row_ff;
      end
   end

   always_comb begin
      push_data.has_a   = close_a;
      push_data.a_start = START_W'(run_start_ff);
      push_data.a_end   = END_W'(col_ff);
      push_data.a_level = run_level_ff;
      push_data.has_b   = close_b;
      push_data.b_start = START_W'(run_start_in);
      push_data.b_end   = END_W'(col_next);
      push_data.b_level = run_level_in;
      push_data.row     = ROW_OUT_W'(row_ff);
   end

   assign push = accept && (close_a || close_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         run_open_ff  <= 1'b0;
         run_level_ff <= '0;
         run_start_ff <= '0;
      end else if (accept) begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         run_open_ff  <= run_open_in;
         run_level_ff <= run_level_in;
         run_start_ff <= run_start_in;
      end
   end

endmodule

FILE: hdl/rrs_queue.sv
// Small FIFO of segment pairs between front and back.
module rrs_queue #(
   parameter int DEPTH = rrs_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rrs_pkg::seg_pair_type push_data,
   output logic                  full,
   input  logic                  pop,
   output rrs_pkg::seg_pair_type pop_data,
   output logic                  empty
);
   import rrs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   seg_pair_type     mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/rrs_back.sv
// Back end: splits segment pairs into single segments, looks up depth.
module rrs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  rrs_pkg::seg_pair_type  pop_data,
   output logic                   pop,
   input  rrs_pkg::depth_cfg_type depth_cfg,
   rrs_rsp_if.source              rsp_ch
);
   import rrs_pkg::*;

   logic               out_valid_ff, out_valid_in;
   seg_out_type        out_seg_ff, out_seg_in;
   logic [DEPTH_W-1:0] out_depth_ff, out_depth_in;
   logic               pend_ff, pend_in;
   seg_out_type        pend_seg_ff, pend_seg_in;

   seg_out_type        seg_a;
   seg_out_type        seg_b;
   logic               load;

   function automatic logic [DEPTH_W-1:0] depth_for(input logic [PIX_W-1:0] lvl,
                                                    input depth_cfg_type cfg);
      logic [DEPTH_W-1:0] d;
      case (lvl)
         LEVEL_ONE:   d = cfg.one;
         LEVEL_TWO:   d = cfg.two;
         LEVEL_THREE: d = cfg.three;
         default:     d = '0;
      endcase
      return d;
   endfunction

   always_comb begin
      seg_a.start   = pop_data.a_start;
      seg_a.end_col = pop_data.a_end;
      seg_a.row     = pop_data.row;
      seg_a.level   = pop_data.a_level;
      seg_a.last    = !pop_data.has_b;
      seg_b.start   = pop_data.b_start;
      seg_b.end_col = pop_data.b_end;
      seg_b.row     = pop_data.row;
      seg_b.level   = pop_data.b_level;
      seg_b.last    = 1'b1;
   end

   assign load = !out_valid_ff || rsp_ch.ready;
   assign pop  = load && !pend_ff && !queue_empty;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_seg_in   = out_seg_ff;
      pend_in      = pend_ff;
      pend_seg_in  = pend_seg_ff;
      if (load) begin
         if (pend_ff) begin
            out_valid_in = 1'b1;
            out_seg_in   = pend_seg_ff;
            pend_in      = 1'b0;
         end else if (!queue_empty) begin
            out_valid_in = 1'b1;
            out_seg_in   = pop_data.has_a ? seg_a : seg_b;
            pend_in      = pop_data.has_a && pop_data.has_b;
            pend_seg_in  = seg_b;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      out_depth_in = depth_for(out_seg_in.level, depth_cfg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_seg_ff   <= out_seg_in;
      out_depth_ff <= out_depth_in;
      pend_seg_ff  <= pend_seg_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.seg_start    = out_seg_ff.start;
   assign rsp_ch.seg_end      = out_seg_ff.end_col;
   assign rsp_ch.seg_row      = out_seg_ff.row;
   assign rsp_ch.seg_level    = out_seg_ff.level;
   assign rsp_ch.seg_depth    = out_depth_ff;
   assign rsp_ch.last_of_item = out_seg_ff.last;

endmodule

FILE: hdl/raster_run_segmenter.sv
// Top level of the raster run segmenter: CSRs, front end, queue, back end.
//
//  channel   dir  handshake        payload
//  req_ch    in   valid / ready    pixel_level[1:0]
//  rsp_ch    out  valid / ready    seg_start, seg_end, seg_row, seg_level,
//                                  seg_depth, last_of_item
//  csr_*     in   csr_we (no wait) csr_index[1:0], csr_wdata[9:0]
//
//  Cycles: one pixel accepted per clock unless the queue is full; one segment
//  leaves per clock while rsp_ch.ready is high. A pixel that closes two runs
//  yields two segments; the queue between front and back absorbs the difference.
//  Path: accepted pixel -> queue -> registered output stage -> rsp_ch.
//  Reset: synchronous, clears run tracking, queue and output stage, and loads
//  the CSR defaults (width 50, depths 60 / 30 / 0).
//  Stalls: req_ch.ready drops only when the queue is full; pixels that close
//  no run are still gated by that same ready.
module raster_run_segmenter #(
   parameter int MAX_WIDTH   = rrs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_ROWS    = rrs_pkg::DEF_MAX_ROWS,
   parameter int QUEUE_DEPTH = rrs_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   rrs_req_if.sink                         req_ch,
   rrs_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [rrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rrs_pkg::*;

   // config registers
   logic [ROW_WIDTH_W-1:0] row_width_ff;
   depth_cfg_type          depth_cfg_ff;

   // front -> queue -> back
   logic         push;
   seg_pair_type push_data;
   logic         queue_full;
   logic         pop;
   seg_pair_type pop_data;
   logic         queue_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff       <= RST_ROW_WIDTH;
         depth_cfg_ff.one   <= RST_DEPTH_ONE;
         depth_cfg_ff.two   <= RST_DEPTH_TWO;
         depth_cfg_ff.three <= RST_DEPTH_THREE;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            CSR_ROW_WIDTH:   row_width_ff       <= csr_wdata[ROW_WIDTH_W-1:0];
            CSR_DEPTH_ONE:   depth_cfg_ff.one   <= csr_wdata[DEPTH_W-1:0];
            CSR_DEPTH_TWO:   depth_cfg_ff.two   <= csr_wdata[DEPTH_W-1:0];
            CSR_DEPTH_THREE: depth_cfg_ff.three <= csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Front: column / row counters and the open run; emits what each pixel closes.
   rrs_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .row_width  (row_width_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // Decoupling queue, one entry per pixel that closed at least one run.
   rrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // Back: one segment per clock, unless rsp_ch stalls, into the output register.
   rrs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .depth_cfg   (depth_cfg_ff),
      .rsp_ch      (rsp_ch)
   );

endmodule

FILE: hdl/rrs_checker.sv
// Port-level checks for the raster run segmenter, bound to the top level.
module rrs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rrs_pkg::START_W-1:0]     seg_start,
   input logic [rrs_pkg::END_W-1:0]       seg_end,
   input logic [rrs_pkg::PIX_W-1:0]       seg_level,
   input logic                            last_of_item
);
   import rrs_pkg::*;

   // output stage is empty right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("segment valid right after reset");

   // a stalled segment stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(seg_start) && $stable(seg_end)
                                     && $stable(last_of_item)))
      else $error("stalled segment changed");

   // runs never carry the blank level
   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (seg_level != LEVEL_NONE))
      else $error("segment with blank level");

   // every run covers at least one pixel
   a_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (seg_end > END_W'(seg_start)))
      else $error("segment end not past start");

endmodule

bind raster_run_segmenter rrs_checker u_rrs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .seg_start    (rsp_ch.seg_start),
   .seg_end      (rsp_ch.seg_end),
   .seg_level    (rsp_ch.seg_level),
   .last_of_item (rsp_ch.last_of_item)
);

FILE: tb/sv/rrs_segment_audit.sv
`timescale 1ns / 100ps
// Watches the pixel and segment channels, predicts segments and checks them in order.
module rrs_segment_audit (
   input  logic                           clock,
   input  logic                           reset,
   rrs_req_if                             req_mon,
   rrs_rsp_if                             rsp_mon,
   input  logic                           csr_we,
   input  logic [rrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rrs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending,
   output int                             seg_checked
);
   import rrs_pkg::*;

   typedef struct {
      logic [START_W-1:0]   start;
      logic [END_W-1:0]     end_col;
      logic [ROW_OUT_W-1:0] row;
      logic [PIX_W-1:0]     level;
      logic [DEPTH_W-1:0]   depth;
      logic                 last;
   } segment_rec;

   segment_rec segments_due[$];

   logic [ROW_WIDTH_W-1:0] cfg_width;
   depth_cfg_type          cfg_depth;

   logic [START_W-1:0]   col_pos;
   logic [ROW_OUT_W-1:0] row_pos;
   logic                 open_run;
   logic [PIX_W-1:0]     open_level;
   logic [START_W-1:0]   open_start;

   function automatic logic [DEPTH_W-1:0] depth_for(input logic [PIX_W-1:0] lvl);
      case (lvl)
         LEVEL_ONE:   return cfg_depth.one;
         LEVEL_TWO:   return cfg_depth.two;
         LEVEL_THREE: return cfg_depth.three;
         default:     return '0;
      endcase
   endfunction

   function automatic segment_rec close_run(input logic [END_W-1:0] end_col);
      segment_rec s;
      s.start   = open_start;
      s.end_col = end_col;
      s.row     = row_pos;
      s.level   = open_level;
      s.depth   = depth_for(open_level);
      s.last    = 1'b0;
      return s;
   endfunction

   // One pixel: close the open run on a level change, open a new one on a
   // nonzero level, and flush whatever is open when the row ends.
   task automatic take_pixel(input logic [PIX_W-1:0] lvl);
      segment_rec closed[$];
      int span;
      int col;
      span = (cfg_width == 0) ? 1 :
             (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(cfg_width);
      col  = int'(col_pos);
      if (open_run && lvl != open_level) begin
         closed.push_back(close_run(END_W'(col)));
         open_run = 1'b0;
      end
      if (!open_run && lvl != LEVEL_NONE) begin
         open_run   = 1'b1;
         open_level = lvl;
         open_start = col_pos;
      end
      // a lowered width can leave the column past the new row end
      if (col + 1 >= span) begin
         if (open_run) begin
            closed.push_back(close_run(END_W'(col + 1)));
            open_run = 1'b0;
         end
         col_pos = '0;
         row_pos = ROW_OUT_W'((int'(row_pos) + 1) % DEF_MAX_ROWS);
      end else begin
         col_pos = START_W'(col + 1);
      end
      if (closed.size() > 0) closed[closed.size() - 1].last = 1'b1;
      foreach (closed[i]) segments_due.push_back(closed[i]);
   endtask

   task automatic check_field(input string name, input logic [DEPTH_W-1:0] want,
                              input logic [DEPTH_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s of segment %0d expected %0d, got %0d",
                  $time, name, seg_checked, want, got);
      end
   endtask

   always @(posedge clock) begin
      segment_rec want;
      if (reset) begin
         cfg_width       = RST_ROW_WIDTH;
         cfg_depth.one   = RST_DEPTH_ONE;
         cfg_depth.two   = RST_DEPTH_TWO;
         cfg_depth.three = RST_DEPTH_THREE;
         col_pos    = '0;
         row_pos    = '0;
         open_run   = 1'b0;
         open_level = LEVEL_NONE;
         open_start = '0;
         segments_due.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (segments_due.size() == 0) begin
               fail_count++;
               $display("%0t: expected no segment, got start %0d end %0d row %0d level %0d",
                        $time, rsp_mon.seg_start, rsp_mon.seg_end, rsp_mon.seg_row,
                        rsp_mon.seg_level);
            end else begin
               want = segments_due.pop_front();
               check_field("seg_start", DEPTH_W'(want.start),
                           DEPTH_W'(rsp_mon.seg_start));
               check_field("seg_end", DEPTH_W'(want.end_col),
                           DEPTH_W'(rsp_mon.seg_end));
               check_field("seg_row", DEPTH_W'(want.row),
                           DEPTH_W'(rsp_mon.seg_row));
               check_field("seg_level", DEPTH_W'(want.level),
                           DEPTH_W'(rsp_mon.seg_level));
               check_field("seg_depth", want.depth, rsp_mon.seg_depth);
               check_field("last_of_item", DEPTH_W'(want.last),
                           DEPTH_W'(rsp_mon.last_of_item));
               seg_checked++;
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            take_pixel(req_mon.pixel_level);
         if (csr_we) begin
            case (csr_index)
               CSR_ROW_WIDTH:   cfg_width       = csr_wdata[ROW_WIDTH_W-1:0];
               CSR_DEPTH_ONE:   cfg_depth.one   = csr_wdata[DEPTH_W-1:0];
               CSR_DEPTH_TWO:   cfg_depth.two   = csr_wdata[DEPTH_W-1:0];
               CSR_DEPTH_THREE: cfg_depth.three = csr_wdata[DEPTH_W-1:0];
               default: ;
            endcase
         end
      end
      pending = segments_due.size();
   end

endmodule

FILE: tb/sv/tb_raster_run_segmenter.sv
`timescale 1ns / 100ps
// Top of the raster run segmenter testbench: clock, reset, pixel stimulus and verdict.
module tb_raster_run_segmenter;
   import rrs_pkg::*;

   localparam int PHASES       = 8;
   localparam int PHASE_PIXELS = 225;      // 8 x 225 = 1800 random pixels
   localparam int LIMIT_CYCLES = 500000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rrs_req_if req_ch ();
   rrs_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int seg_checked;

   // idling knobs, changed per phase; calm switches all idling off
   int gap_pct;
   int stall_pct;
   bit calm;

   int pixels_sent;
   int reg_writes;
   int cycle_count;

   raster_run_segmenter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rrs_segment_audit i_audit (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .seg_checked (seg_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: anything left waiting this long is a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d segments still due", $time, pending);
         $display("[raster_run_segmenter] ERROR");
         $finish;
      end
   end

   // Segment sink: ready drops in random bursts, odds set per phase.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) stall_left = 0;
         else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 10);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Called at a falling edge with the pixel channel idle.
   task automatic set_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      reg_writes++;
   endtask

   // Present one pixel, maybe after a gap, and return at the falling edge
   // after it was taken. valid stays high so the next pixel follows at once.
   task automatic send_pixel(input logic [PIX_W-1:0] lvl);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.pixel_level = lvl;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Drain: all predicted segments out, then an idle wait so that a pixel that
   // closed nothing clears the pipe before the next register write.
   task automatic settle();
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_depth();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return 10'd1023;
         default: return CSR_DATA_W'($urandom_range(0, 1023));
      endcase
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] width_val;
      logic [PIX_W-1:0]      lvl;
      int                    keep_pct;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_ROW_WIDTH;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.pixel_level = LEVEL_NONE;
      gap_pct            = 0;
      stall_pct          = 0;
      calm               = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed: short rows, depth extremes ---
      gap_pct   = 20;
      stall_pct = 20;
      set_reg(CSR_ROW_WIDTH,   10'd4);
      set_reg(CSR_DEPTH_ONE,   10'd1023);
      set_reg(CSR_DEPTH_TWO,   10'd0);
      set_reg(CSR_DEPTH_THREE, 10'd517);
      // two runs, each ending on a level change / the row end
      send_pixel(LEVEL_ONE);   send_pixel(LEVEL_ONE);
      send_pixel(LEVEL_TWO);   send_pixel(LEVEL_TWO);
      // blank pixel splits two level-three runs
      send_pixel(LEVEL_THREE); send_pixel(LEVEL_NONE);
      send_pixel(LEVEL_THREE); send_pixel(LEVEL_THREE);
      // each nonblank pixel is closed by the pixel after it
      send_pixel(LEVEL_NONE);  send_pixel(LEVEL_ONE);
      send_pixel(LEVEL_TWO);   send_pixel(LEVEL_NONE);
      // last pixel closes a run and is a one-pixel run itself: two segments
      send_pixel(LEVEL_NONE);  send_pixel(LEVEL_NONE);
      send_pixel(LEVEL_ONE);   send_pixel(LEVEL_TWO);
      settle();

      // width zero behaves as one pixel per row
      set_reg(CSR_ROW_WIDTH, 10'd0);
      send_pixel(LEVEL_THREE); send_pixel(LEVEL_NONE); send_pixel(LEVEL_ONE);
      settle();

      // only the low seven bits land: width 5; then shrink the width mid-row
      set_reg(CSR_ROW_WIDTH, 10'h385);
      send_pixel(LEVEL_TWO);   send_pixel(LEVEL_TWO);
      settle();
      set_reg(CSR_ROW_WIDTH, 10'd2);
      send_pixel(LEVEL_TWO);
      settle();

      // --- random phases, new settings each time; column carries over ---
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       width_val = 10'd1;     // row index wraps more than once
            1:       width_val = 10'd127;   // clamps to the widest row
            2:       width_val = 10'd64;
            default: begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: width_val = CSR_DATA_W'($urandom_range(1, 8));
                  5, 6, 7:       width_val = CSR_DATA_W'($urandom_range(9, 64));
                  8:             width_val = '0;
                  default:       width_val = CSR_DATA_W'($urandom_range(65, 127));
               endcase
            end
         endcase
         set_reg(CSR_ROW_WIDTH,   width_val);
         set_reg(CSR_DEPTH_ONE,   pick_depth());
         set_reg(CSR_DEPTH_TWO,   pick_depth());
         set_reg(CSR_DEPTH_THREE, pick_depth());

         gap_pct   = 15 * $urandom_range(0, 2);
         stall_pct = 15 * $urandom_range(0, 2);
         calm      = (phase == PHASES - 1);

         // keep_pct sets how long runs get: high for long runs, low for noise
         keep_pct = $urandom_range(20, 90);
         lvl      = PIX_W'($urandom_range(0, 3));
         repeat (PHASE_PIXELS) begin
            if ($urandom_range(0, 99) >= keep_pct) lvl = PIX_W'($urandom_range(0, 3));
            send_pixel(lvl);
         end
         settle();
      end

      // catch any stray segment after the last one expected
      repeat (20) @(posedge clock);

      $display("Covered %0d pixels with %0d register writes; %0d segments checked.",
               pixels_sent, reg_writes, seg_checked);
      if (fail_count == 0) begin
         $display("[raster_run_segmenter] OK");
      end else begin
         $display("%0d failures", fail_count);
         $display("[raster_run_segmenter] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/rrs_pkg.sv
hdl/rrs_req_if.sv
hdl/rrs_rsp_if.sv
hdl/rrs_front.sv
hdl/rrs_queue.sv
hdl/rrs_back.sv
hdl/raster_run_segmenter.sv
hdl/rrs_checker.sv
tb/sv/rrs_segment_audit.sv
tb/sv/tb_raster_run_segmenter.sv
